>>> design/stepper_ramp_interval_generator_core_defines.svh
// Assertion macros shared by the stepper ramp generator RTL.
// Used by the top level; no other dependencies.
`ifndef STEPPER_RAMP_INTERVAL_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_INTERVAL_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRIG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srig check failed");

// Next-cycle implication, checked out of reset.
`define SRIG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srig check failed");

`endif

>>> design/srig_pkg.sv
// Constants for the stepper ramp interval generator.
// No dependencies; imported by the top level.
package srig_pkg;
    localparam int CHANNELS_DEF      = 3;
    localparam int TICK_CLOCK_HZ_DEF = 10000000;
    localparam int DELAY_W           = 24;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
    localparam logic [44:0] DELAY_OFFSET = 45'd33;
    // dividend width: covers tick clock * 2^16 plus half a Q16.16 speed
    localparam int DIV_W   = 45;
    localparam int SQRT_IT = 32;
    localparam logic       FUNC_START = 1'b0;
    localparam logic       FUNC_NEXT  = 1'b1;
endpackage

>>> design/stepper_ramp_interval_generator_core.sv
// Stepper ramp interval generator: per-channel trapezoidal pulse delays.
// Depends on srig_pkg and stepper_ramp_interval_generator_core_defines.svh.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall): func 0 starts a move on a channel
//  (steps, start rate, peak rate, acceleration); func 1 asks that channel for
//  its next pulse delay. Items to a channel number at or above CHANNELS, and
//  requests to an idle channel, are dropped without a result.
//  Output channel (o_out_valid / i_out_stall): one transfer per granted
//  request carrying channel, delay in ticks minus 33 and a last-pulse flag.
//  Sequencing: one item is worked at a time. A start item runs through
//  square, subtract, a 45-step radix-2 divider with its exit check, and
//  commit; with zero acceleration the divider is skipped. A pulse request
//  runs from its transfer to o_out_valid through product, add, a 32-step
//  bit-pair square root with its exit check, the same divider, and commit;
//  with zero speed the divider is skipped. o_in_stall is high from the
//  transfer until the commit, so no new item is taken before the last one
//  is committed.
//  The shared serial root and divider set the rate.
//  The result sits in an output register; while it is stalled the next item
//  is still taken and worked; only a pulse request's commit waits for it.
//  Reset (synchronous, active low) makes every channel idle; no clearing pass.
module stepper_ramp_interval_generator_core #(
    parameter int CHANNELS      = srig_pkg::CHANNELS_DEF,
    parameter int TICK_CLOCK_HZ = srig_pkg::TICK_CLOCK_HZ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_move_steps,
    input  logic [15:0] i_start_rate,
    input  logic [15:0] i_max_rate,
    input  logic [19:0] i_accel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_channel,
    output logic [srig_pkg::DELAY_W-1:0] o_delay,
    output logic        o_last
);
    import srig_pkg::*;
    `include "stepper_ramp_interval_generator_core_defines.svh"

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [DIV_W-1:0] TICK_NUM = DIV_W'(TICK_CLOCK_HZ) << 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [1:0] M_CRUISE = 2'd0;
    localparam logic [1:0] M_ACCEL  = 2'd1;
    localparam logic [1:0] M_BRAKE  = 2'd2;

    // per-channel move state
    logic signed [31:0] r_ramp   [CHANNELS];
    logic [15:0]        r_index  [CHANNELS];
    logic [15:0]        r_total  [CHANNELS];
    logic [31:0]        r_speed  [CHANNELS];
    logic [19:0]        r_acc    [CHANNELS];
    logic [CHANNELS-1:0] r_active;

    // item being worked
    logic [2:0]  r_state;
    logic        r_func;
    logic [1:0]  r_ch;
    logic [15:0] r_steps;
    logic [15:0] r_v0;
    logic [15:0] r_v1;
    logic [19:0] r_a;
    logic [1:0]  r_mode;
    logic        r_neg;
    logic        r_vzero;
    logic [31:0] r_sq1;
    logic [31:0] r_sq0;
    logic [63:0] r_rad;
    logic [63:0] r_term;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic [DIV_W-1:0] r_dvd;
    logic [31:0] r_drem;
    logic [31:0] r_dvs;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_ch;
    logic [DELAY_W-1:0] r_out_delay;
    logic        r_out_last;

    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] idx;
    logic             in_ok;

    assign in_idx = IDX_W'(i_channel);
    assign idx    = IDX_W'(r_ch);
    assign in_ok  = ({30'd0, i_channel} < CHANNELS) &&
                    ((i_func == FUNC_START) || r_active[in_idx]);

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_delay       = r_out_delay;
    assign o_last        = r_out_last;

    // ramp segment for a pulse request
    logic signed [33:0] seg_i;
    logic signed [33:0] seg_s;
    logic signed [33:0] seg_ns;
    logic [1:0]         seg_mode;
    always_comb begin
        seg_i  = $signed({18'd0, r_index[idx]});
        seg_s  = $signed({{2{r_ramp[idx][31]}}, r_ramp[idx]});
        seg_ns = $signed({18'd0, r_total[idx]}) - seg_s;
        if (seg_i < seg_s && r_index[idx] < (r_total[idx] >> 1)) begin
            seg_mode = M_ACCEL;
        end else if (seg_i >= seg_ns) begin
            seg_mode = M_BRAKE;
        end else begin
            seg_mode = M_CRUISE;
        end
    end

    // radicand update and ramp numerator
    logic [64:0] rad_sum;
    logic [32:0] diff;
    logic [32:0] mag;
    assign rad_sum = {1'b0, r_rad} + {1'b0, r_term};
    assign diff    = {1'b0, r_sq1} - {1'b0, r_sq0};
    assign mag     = diff[32] ? (33'd0 - diff) : diff;

    // one bit-pair root step
    logic [33:0] sq_cand;
    logic [33:0] sq_trial;
    assign sq_cand  = {r_rem[31:0], r_rad[63:62]};
    assign sq_trial = {r_root, 2'b01};

    // one restoring divide step
    logic [32:0] dv_cand;
    logic        dv_ge;
    assign dv_cand = {r_drem, r_dvd[DIV_W-1]};
    assign dv_ge   = (dv_cand >= {1'b0, r_dvs});

    // commit values
    logic [15:0]        idx_next;
    logic               is_last;
    logic [DELAY_W-1:0] delay_val;
    logic [DIV_W-1:0]   q_off;
    logic               out_free;
    logic               out_load;
    always_comb begin
        idx_next = r_index[idx] + 16'd1;
        is_last  = (idx_next >= r_total[idx]);
        q_off    = r_dvd - DELAY_OFFSET;
        if (r_vzero) begin
            delay_val = DELAY_MAX;
        end else if (r_dvd <= DELAY_OFFSET) begin
            delay_val = '0;
        end else if (q_off > DIV_W'(DELAY_MAX)) begin
            delay_val = DELAY_MAX;
        end else begin
            delay_val = q_off[DELAY_W-1:0];
        end
    end
    assign out_free = !r_out_valid || !i_out_stall;
    // a pulse result enters the output register this cycle
    assign out_load = (r_state == S_FIN) && (r_func == FUNC_NEXT) && out_free;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && in_ok) begin
                        r_func  <= i_func;
                        r_ch    <= i_channel;
                        r_steps <= i_move_steps;
                        r_v0    <= i_start_rate;
                        r_v1    <= i_max_rate;
                        r_a     <= i_accel;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sq1  <= {16'd0, r_v1} * {16'd0, r_v1};
                    r_sq0  <= {16'd0, r_v0} * {16'd0, r_v0};
                    r_rad  <= {32'd0, r_speed[idx]} * {32'd0, r_speed[idx]};
                    r_term <= {11'd0, r_acc[idx], 1'b0, 32'd0};
                    r_mode <= seg_mode;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_func == FUNC_START) begin
                        r_neg  <= diff[32];
                        r_dvd  <= DIV_W'(mag) + DIV_W'(r_a);
                        r_dvs  <= {11'd0, r_a, 1'b0};
                        r_drem <= '0;
                        r_cnt  <= 6'(DIV_W);
                        if (r_a == 20'd0) begin
                            r_vzero <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_vzero <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        case (r_mode)
                            M_ACCEL: r_rad <= rad_sum[64] ? '1 : rad_sum[63:0];
                            M_BRAKE: r_rad <= (r_rad >= r_term) ? (r_rad - r_term) : '0;
                            default: r_rad <= r_rad;
                        endcase
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 6'(SQRT_IT);
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_vzero <= (r_root == 32'd0);
                        r_dvd   <= TICK_NUM + DIV_W'(r_root >> 1);
                        r_dvs   <= r_root;
                        r_drem  <= '0;
                        r_cnt   <= 6'(DIV_W);
                        r_state <= (r_root == 32'd0) ? S_FIN : S_DIV;
                    end else begin
                        r_rad <= {r_rad[61:0], 2'b00};
                        if (sq_cand >= sq_trial) begin
                            r_rem  <= sq_cand - sq_trial;
                            r_root <= {r_root[30:0], 1'b1};
                        end else begin
                            r_rem  <= sq_cand;
                            r_root <= {r_root[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_drem <= dv_ge ? 32'(dv_cand - {1'b0, r_dvs}) : dv_cand[31:0];
                        r_dvd  <= {r_dvd[DIV_W-2:0], dv_ge};
                        r_cnt  <= r_cnt - 6'd1;
                    end
                end
                S_FIN: begin
                    if (r_func == FUNC_START) begin
                        if (r_vzero) begin
                            r_ramp[idx] <= '0;
                        end else if (r_neg) begin
                            r_ramp[idx] <= 32'sd0 - $signed(r_dvd[31:0]);
                        end else begin
                            r_ramp[idx] <= $signed(r_dvd[31:0]);
                        end
                        r_speed[idx]  <= {r_v0, 16'd0};
                        r_acc[idx]    <= r_a;
                        r_index[idx]  <= '0;
                        r_total[idx]  <= r_steps;
                        r_active[idx] <= (r_steps != 16'd0);
                        r_state       <= S_IDLE;
                    end else if (out_free) begin
                        r_speed[idx]  <= r_root;
                        r_index[idx]  <= idx_next;
                        r_active[idx] <= !is_last;
                        r_out_valid   <= 1'b1;
                        r_out_ch      <= r_ch;
                        r_out_delay   <= delay_val;
                        r_out_last    <= is_last;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `SRIG_ASSERT_NOW(a_out_from_fin, $rose(r_out_valid), $past(r_state) == S_FIN)
    `SRIG_ASSERT_NOW(a_out_from_next, $rose(r_out_valid), $past(r_func) == FUNC_NEXT)
    `SRIG_ASSERT_NEXT(a_div_exit, r_state == S_DIV, r_state == S_DIV || r_state == S_FIN)

endmodule
